>>> rtl/i2cm_pkg.sv
// i2cm_pkg: phase codes, command kinds, state, tick and result types, register
// indexes and reset values shared by the i2c master byte engine modules. no dependencies.
`timescale 1ns / 1ps

package i2cm_pkg;

  localparam int unsigned CFG_W = 16;

  localparam logic [CFG_W-1:0] PHASE_TICKS_RESET   = 16'd600;
  localparam logic [CFG_W-1:0] STRETCH_LIMIT_RESET = 16'h03FF;

  // configuration register indexes
  localparam logic CFG_PHASE_TICKS   = 1'b0;
  localparam logic CFG_STRETCH_LIMIT = 1'b1;

  // command kinds
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_STOP  = 3'd2;
  localparam logic [2:0] KIND_WRITE = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_W    = 5'd2,
    PH_ST_B    = 5'd3,
    PH_ST_C    = 5'd4,
    PH_ST_D    = 5'd5,
    PH_SP_A    = 5'd6,
    PH_SP_B    = 5'd7,
    PH_SP_W    = 5'd8,
    PH_SP_C    = 5'd9,
    PH_SP_D    = 5'd10,
    PH_W_SETUP = 5'd11,
    PH_W_HIGH  = 5'd12,
    PH_W_WAIT  = 5'd13,
    PH_W_POLL  = 5'd14,
    PH_W_HOLD  = 5'd15,
    PH_W_LOW   = 5'd16,
    PH_R_SETUP = 5'd17,
    PH_R_HIGH  = 5'd18,
    PH_R_WAIT  = 5'd19,
    PH_R_HOLD  = 5'd20,
    PH_R_SHOLD = 5'd21,
    PH_R_LOW   = 5'd22,
    PH_R_TAIL  = 5'd23
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] delay_count;
    logic [15:0] stretch_count;
    logic [3:0]  bit_index;
    logic [7:0]  shift_byte;
    logic        scl_rel;
    logic        sda_rel;
    logic        ack_status;
    logic        nack_to_send;
    logic [7:0]  rx_last;
  } st_t;

  typedef struct packed {
    logic       got_nack;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_release;
    logic       scl_release;
  } res_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       send_nack;
    logic       scl_level;
    logic       sda_level;
  } tick_t;

endpackage

>>> rtl/i2cm_step.sv
// i2cm_step: next-state logic for one tick of the bus sequencer.
// depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_step import i2cm_pkg::*; (
  input  st_t         cur,
  input  tick_t       tick,
  input  logic [15:0] phase_ticks,
  input  logic [15:0] stretch_limit,
  output st_t         nxt,
  output logic        done
);

  logic [16:0] delay_inc;
  logic [16:0] delay_lim;
  logic        delay_done;
  logic [16:0] stretch_inc;
  logic        stretch_hit;
  st_t         tmp;

  // enter a phase: clear the counters and apply that phase's line change
  function automatic st_t enter_phase(input st_t s, input phase_t p);
    st_t r;
    r = s;
    r.phase         = p;
    r.delay_count   = '0;
    r.stretch_count = '0;
    case (p)
      PH_ST_A, PH_SP_B, PH_W_HIGH, PH_R_HIGH: r.scl_rel = 1'b1;
      PH_ST_C, PH_SP_A:                       r.sda_rel = 1'b0;
      PH_ST_D, PH_W_LOW, PH_R_LOW:            r.scl_rel = 1'b0;
      PH_SP_D: begin
        r.scl_rel = 1'b1;
        r.sda_rel = 1'b1;
      end
      PH_W_SETUP: r.sda_rel = (s.bit_index < 4'd8) ? s.shift_byte[7] : 1'b1;
      PH_R_SETUP: r.sda_rel = (s.bit_index < 4'd8) ? 1'b1 : s.nack_to_send;
      PH_R_TAIL:  r.sda_rel = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  assign delay_inc   = {1'b0, cur.delay_count} + 17'd1;
  assign delay_lim   = (phase_ticks == '0) ? 17'd1 : {1'b0, phase_ticks};
  assign delay_done  = (delay_inc >= delay_lim);
  assign stretch_inc = {1'b0, cur.stretch_count} + 17'd1;
  assign stretch_hit = (stretch_inc >= {1'b0, stretch_limit});

  always_comb begin
    nxt  = cur;
    tmp  = cur;
    done = 1'b0;
    case (cur.phase)
      PH_IDLE: begin
        tmp.bit_index = '0;
        nxt = tmp;
        case (tick.kind)
          KIND_START: nxt = enter_phase(tmp, PH_ST_A);
          KIND_STOP:  nxt = enter_phase(tmp, PH_SP_A);
          KIND_WRITE: begin
            tmp.shift_byte = tick.tx_byte;
            nxt = enter_phase(tmp, PH_W_SETUP);
          end
          KIND_READ: begin
            tmp.shift_byte   = '0;
            tmp.nack_to_send = tick.send_nack;
            nxt = enter_phase(tmp, PH_R_SETUP);
          end
          default: ;
        endcase
      end
      // scl waits: a high sample or the stretch limit ends them
      PH_ST_W, PH_SP_W, PH_W_WAIT, PH_R_WAIT: begin
        if (tick.scl_level || stretch_hit) begin
          case (cur.phase)
            PH_ST_W:   nxt = enter_phase(cur, PH_ST_B);
            PH_SP_W:   nxt = enter_phase(cur, PH_SP_C);
            PH_W_WAIT: nxt = enter_phase(cur,
                               (cur.bit_index >= 4'd8) ? PH_W_POLL : PH_W_HOLD);
            default:   nxt = enter_phase(cur, PH_R_HOLD);
          endcase
        end else begin
          nxt.stretch_count = stretch_inc[15:0];
        end
      end
      PH_W_POLL: begin
        tmp.ack_status = tick.sda_level;
        if (!tick.sda_level || stretch_hit) begin
          nxt = enter_phase(tmp, PH_W_HOLD);
        end else begin
          nxt = tmp;
          nxt.stretch_count = stretch_inc[15:0];
        end
      end
      PH_ST_A, PH_ST_B, PH_ST_C, PH_SP_A, PH_SP_B, PH_SP_C, PH_W_SETUP, PH_W_HIGH,
      PH_W_HOLD, PH_R_SETUP, PH_R_HIGH, PH_R_SHOLD: begin
        if (delay_done) begin
          case (cur.phase)
            PH_ST_A:    nxt = enter_phase(cur, PH_ST_W);
            PH_ST_B:    nxt = enter_phase(cur, PH_ST_C);
            PH_ST_C:    nxt = enter_phase(cur, PH_ST_D);
            PH_SP_A:    nxt = enter_phase(cur, PH_SP_B);
            PH_SP_B:    nxt = enter_phase(cur, PH_SP_W);
            PH_SP_C:    nxt = enter_phase(cur, PH_SP_D);
            PH_W_SETUP: nxt = enter_phase(cur, PH_W_HIGH);
            PH_W_HIGH:  nxt = enter_phase(cur, PH_W_WAIT);
            PH_W_HOLD:  nxt = enter_phase(cur, PH_W_LOW);
            PH_R_SETUP: nxt = enter_phase(cur, PH_R_HIGH);
            PH_R_HIGH:  nxt = enter_phase(cur, PH_R_WAIT);
            default:    nxt = enter_phase(cur, PH_R_LOW);
          endcase
        end else begin
          nxt.delay_count = delay_inc[15:0];
        end
      end
      PH_R_HOLD: begin
        if (delay_done) begin
          if (cur.bit_index < 4'd8) begin
            tmp.shift_byte = {cur.shift_byte[6:0], tick.sda_level};
            nxt = enter_phase(tmp, PH_R_SHOLD);
          end else begin
            nxt = enter_phase(cur, PH_R_LOW);
          end
        end else begin
          nxt.delay_count = delay_inc[15:0];
        end
      end
      PH_W_LOW: begin
        if (delay_done) begin
          if (cur.bit_index >= 4'd8) begin
            nxt  = enter_phase(cur, PH_IDLE);
            done = 1'b1;
          end else begin
            tmp.shift_byte = {cur.shift_byte[6:0], 1'b0};
            tmp.bit_index  = cur.bit_index + 4'd1;
            nxt = enter_phase(tmp, PH_W_SETUP);
          end
        end else begin
          nxt.delay_count = delay_inc[15:0];
        end
      end
      PH_R_LOW: begin
        if (delay_done) begin
          if (cur.bit_index >= 4'd8) begin
            nxt = enter_phase(cur, PH_R_TAIL);
          end else begin
            tmp.bit_index = cur.bit_index + 4'd1;
            nxt = enter_phase(tmp, PH_R_SETUP);
          end
        end else begin
          nxt.delay_count = delay_inc[15:0];
        end
      end
      PH_R_TAIL: begin
        if (delay_done) begin
          tmp.rx_last = cur.shift_byte;
          nxt  = enter_phase(tmp, PH_IDLE);
          done = 1'b1;
        end else begin
          nxt.delay_count = delay_inc[15:0];
        end
      end
      PH_ST_D, PH_SP_D: begin
        if (delay_done) begin
          nxt  = enter_phase(cur, PH_IDLE);
          done = 1'b1;
        end else begin
          nxt.delay_count = delay_inc[15:0];
        end
      end
      default: nxt = enter_phase(cur, PH_IDLE);
    endcase
  end

endmodule

>>> rtl/i2cm_core.sv
// i2cm_core: configuration registers and sequencer state register; builds
// the result of each accepted tick. depends on i2cm_pkg and i2cm_step.
`timescale 1ns / 1ps

module i2cm_core import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        tick_en,
  input  tick_t       tick,
  output res_t        res
);

  logic [15:0] phase_ticks;
  logic [15:0] stretch_limit;
  st_t         st;
  st_t         st_next;
  logic        done;

  i2cm_step u_step (
    .cur           (st),
    .tick          (tick),
    .phase_ticks   (phase_ticks),
    .stretch_limit (stretch_limit),
    .nxt           (st_next),
    .done          (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks   <= PHASE_TICKS_RESET;
      stretch_limit <= STRETCH_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PHASE_TICKS:   phase_ticks   <= cfg_data;
        CFG_STRETCH_LIMIT: stretch_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_IDLE;
      st.delay_count   <= '0;
      st.stretch_count <= '0;
      st.bit_index     <= '0;
      st.shift_byte    <= '0;
      st.scl_rel       <= 1'b1;
      st.sda_rel       <= 1'b1;
      st.ack_status    <= 1'b0;
      st.nack_to_send  <= 1'b0;
      st.rx_last       <= '0;
    end else if (tick_en) begin
      st <= st_next;
    end
  end

  // result is taken from the state after this tick's update
  always_comb begin
    res.scl_release = st_next.scl_rel;
    res.sda_release = st_next.sda_rel;
    res.busy_res    = (st_next.phase != PH_IDLE);
    res.done_res    = done;
    res.rx_byte     = st_next.rx_last;
    res.got_nack    = st_next.ack_status;
  end

endmodule

>>> rtl/i2cm_out.sv
// i2cm_out: output register of the result stream; frees the input side
// whenever the register is empty or drains this cycle. depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_out import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  res_t        res,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {3'b000, res};
    end
  end

endmodule

>>> rtl/i2c_master_byte_engine_top.sv
// i2c_master_byte_engine_top: tick-driven i2c master with clock stretching
// and ack polling. depends on i2cm_pkg, i2cm_step, i2cm_core, i2cm_out.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid / s_tready  one bus tick: sampled lines + command
//   m_*       out   m_tvalid / m_tready  one result per tick: line drives, status
//   cfg_*     in    cfg_we               register write, index 0 phase_ticks,
//                                        index 1 stretch_limit
//
// next-state logic sits between the state register and the output register,
// so a tick can be accepted each cycle the output register is empty or being
// drained.
// the result of a tick is registered and appears on m_* in the cycle after the tick is accepted.
// a stall on m_tready holds the result and drops s_tready until it drains.
// rst is synchronous, active high: sequencer idle, both lines released,
// phase_ticks 600, stretch_limit 1023, output register empty.
`timescale 1ns / 1ps

module i2c_master_byte_engine_top import i2cm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // tick stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // tx_byte[7:0], send_nack[8], scl_level[9], sda_level[10]
  input  logic [2:0]  s_tuser,  // kind[2:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // scl_release[0], sda_release[1], busy_res[2],
                                // done_res[3], rx_byte[11:4], got_nack[12]
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  tick_t tick;
  res_t  res;
  logic  accept;
  logic  free;

  assign tick.kind      = s_tuser;
  assign tick.tx_byte   = s_tdata[7:0];
  assign tick.send_nack = s_tdata[8];
  assign tick.scl_level = s_tdata[9];
  assign tick.sda_level = s_tdata[10];

  assign s_tready = free;
  assign accept   = s_tvalid && free;

  i2cm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick_en   (accept),
    .tick      (tick),
    .res       (res)
  );

  i2cm_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .res      (res),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> rtl/i2cm_checker.sv
// i2cm_checker: port-level checks of the i2c master byte engine, bound to
// the top level. depends on the top level's port list only.
`timescale 1ns / 1ps

module i2cm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a finished command never reads as still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
    else $error("done and busy set in the same result");

  // every accepted tick yields a result in the next cycle
  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted tick without a result");

  // no tick is taken while a result is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("tick accepted over a stalled result");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
